@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the distance-vector table RTL.
// The enclosing module must provide clk and rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/dvtu_pkg.sv @@
// Shared types, widths and codes of the distance-vector table update block.
// No dependencies; every RTL module imports it.
package dvtu_pkg;

  localparam int ID_W          = 6;
  localparam int COST_W        = 16;
  localparam int LINK_W        = 17;
  localparam int NODES_DEFAULT = 64;

  localparam logic [COST_W-1:0] COST_INF = '1;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_SET    = 2'd1;
  localparam logic [1:0] OP_CHANGE = 2'd2;
  localparam logic [1:0] OP_RELAX  = 2'd3;

  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic [ID_W-1:0]   next;
    logic              valid;
  } entry_t;

  typedef struct packed {
    entry_t ent;
    logic   changed;
  } result_t;

endpackage

@@ hw/rtl/distance_vector_table_update_top.sv @@
// Top level of the distance-vector table update block: input stage, table,
// update logic and result register. Depends on dvtu_pkg, dvtu_table,
// dvtu_update and assert_macros.svh.
//
// Usage: each word on the in channel (opcode, dest_node, neighbor_node,
// link_cost, advertised_cost) works on the table entry of dest_node and
// yields one word on the out channel holding that entry afterwards plus a
// changed flag. Both channels use valid/ready. The cfg channel writes
// self_id and is ready whenever reset is low; write it only while the block
// is idle. Accepted words pass the input stage and the result register,
// which raises out_valid. Throughput is one word per cycle while the
// receiver does not stall: the table read is issued at acceptance, the
// entry is updated and written back as the word leaves the input stage,
// and a same-cycle write to the read address reaches the following word.
// When the receiver stalls, the result register holds; the input stage
// still takes one more word, and then in_ready drops until out_ready.
// Reset clears self_id and the pipeline valid flags, and holds in_ready and
// cfg_ready low. Table contents are not cleared: every entry must be written
// by a clear word before use.
// A dest_node at or beyond NODES writes nothing and returns all zeros.
module distance_vector_table_update_top
  import dvtu_pkg::*;
#(
  parameter int NODES = NODES_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [ID_W-1:0]   cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        opcode,
  input  logic [ID_W-1:0]   dest_node,
  input  logic [ID_W-1:0]   neighbor_node,
  input  logic [LINK_W-1:0] link_cost,
  input  logic [COST_W-1:0] advertised_cost,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [COST_W-1:0] entry_cost,
  output logic [ID_W-1:0]   entry_next,
  output logic              entry_next_valid,
  output logic              entry_changed
);

  `include "assert_macros.svh"

  localparam int CMP_W = 9;

  logic [ID_W-1:0]   self_id;
  logic              s1_valid;
  logic [1:0]        s1_op;
  logic [ID_W-1:0]   s1_dest;
  logic [ID_W-1:0]   s1_nbr;
  logic [LINK_W-1:0] s1_link;
  logic [COST_W-1:0] s1_adv;
  logic              s1_adv_go;
  logic              s1_dest_ok;
  logic              in_acc;
  entry_t            old_ent;
  result_t           res;

  assign cfg_ready = !rst;
  assign s1_adv_go = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !rst && (!s1_valid || !out_valid || out_ready);
  assign in_acc    = in_valid && in_ready;
  assign s1_dest_ok = ({{(CMP_W-ID_W){1'b0}}, s1_dest} < CMP_W'(NODES));

  always_ff @(posedge clk) begin
    if (rst) begin
      self_id <= '0;
    end else if (cfg_valid && cfg_ready) begin
      self_id <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op   <= opcode;
      s1_dest <= dest_node;
      s1_nbr  <= neighbor_node;
      s1_link <= link_cost;
      s1_adv  <= advertised_cost;
    end
  end

  dvtu_table #(
    .NODES(NODES)
  ) u_table (
    .clk    (clk),
    .rd_en  (in_acc),
    .rd_addr(dest_node),
    .wr_en  (s1_adv_go && s1_dest_ok),
    .wr_addr(s1_dest),
    .wr_data(res.ent),
    .rd_data(old_ent)
  );

  dvtu_update u_update (
    .op       (s1_op),
    .dest     (s1_dest),
    .nbr      (s1_nbr),
    .link_cost(s1_link),
    .adv      (s1_adv),
    .self_id  (self_id),
    .dest_ok  (s1_dest_ok),
    .old      (old_ent),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv_go) begin
      entry_cost       <= res.ent.cost;
      entry_next       <= res.ent.next;
      entry_next_valid <= res.ent.valid;
      entry_changed    <= res.changed;
    end
  end

  `ASSERT_ALWAYS(a_reset_empty, rst |=> !s1_valid && !out_valid,
                 "pipeline not empty after reset")
  `ASSERT_CLK(a_accept_fills, in_acc |=> s1_valid,
              "accepted word did not reach the input stage")
  `ASSERT_CLK(a_stall_blocks, s1_valid && !s1_adv_go |-> !in_ready,
              "input taken while the input stage is stalled")
  `ASSERT_CLK(a_clear_self,
              s1_adv_go && s1_dest_ok && s1_op == OP_CLEAR && s1_dest == self_id
              |=> entry_cost == '0 && entry_next_valid && entry_next == self_id,
              "clear of own entry gave a wrong result")

endmodule

@@ hw/rtl/dvtu_table.sv @@
// Routing table storage: one write port, one registered read port, and a
// bypass for a write that lands on the address read at the same edge.
// Depends on dvtu_pkg.
module dvtu_table
  import dvtu_pkg::*;
#(
  parameter int NODES = NODES_DEFAULT
) (
  input  logic            clk,
  input  logic            rd_en,
  input  logic [ID_W-1:0] rd_addr,
  input  logic            wr_en,
  input  logic [ID_W-1:0] wr_addr,
  input  entry_t          wr_data,
  output entry_t          rd_data
);

  localparam int AW = $clog2(NODES);

  entry_t mem [NODES];
  entry_t rd_q;
  entry_t fwd_q;
  logic   fwd_hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[AW'(wr_addr)] <= wr_data;
    end
    if (rd_en) begin
      rd_q    <= mem[AW'(rd_addr)];
      // The array read above returns the old word, so remember the new one.
      fwd_hit <= wr_en && (wr_addr == rd_addr);
      fwd_q   <= wr_data;
    end
  end

  assign rd_data = fwd_hit ? fwd_q : rd_q;

endmodule

@@ hw/rtl/dvtu_update.sv @@
// Next-entry logic: applies one opcode to the current table entry.
// Depends on dvtu_pkg.
module dvtu_update
  import dvtu_pkg::*;
(
  input  logic [1:0]        op,
  input  logic [ID_W-1:0]   dest,
  input  logic [ID_W-1:0]   nbr,
  input  logic [LINK_W-1:0] link_cost,
  input  logic [COST_W-1:0] adv,
  input  logic [ID_W-1:0]   self_id,
  input  logic              dest_ok,
  input  entry_t            old,
  output result_t           res
);

  logic              lneg;
  logic [COST_W-1:0] lcost;
  logic [COST_W:0]   sum_raw;
  logic [COST_W-1:0] sum;
  logic              better;
  entry_t            ent;

  always_comb begin
    lneg    = link_cost[LINK_W-1];
    lcost   = lneg ? COST_INF : link_cost[COST_W-1:0];
    sum_raw = {1'b0, lcost} + {1'b0, adv};
    if (lcost == COST_INF || adv == COST_INF) begin
      sum = COST_INF;
    end else if (sum_raw > {1'b0, COST_INF}) begin
      sum = COST_INF;
    end else begin
      sum = sum_raw[COST_W-1:0];
    end
    // An infinite current cost loses to any finite sum.
    better = (sum != COST_INF) && (old.cost == COST_INF || sum < old.cost);

    ent = old;
    unique case (op)
      OP_CLEAR: begin
        if (dest == self_id) begin
          ent = '{cost: '0, next: self_id, valid: 1'b1};
        end else begin
          ent = '{cost: COST_INF, next: '0, valid: 1'b0};
        end
      end
      OP_SET: begin
        if (lneg) begin
          ent = '{cost: COST_INF, next: '0, valid: 1'b0};
        end else begin
          ent = '{cost: lcost, next: nbr, valid: 1'b1};
        end
      end
      OP_CHANGE: begin
        if (lneg) begin
          ent = '{cost: COST_INF, next: '0, valid: 1'b0};
        end else begin
          ent.cost = lcost;
        end
      end
      OP_RELAX: begin
        if (dest != self_id) begin
          if (better) begin
            ent = '{cost: sum, next: nbr, valid: 1'b1};
          end else if (sum == old.cost) begin
            if (nbr != dest && old.valid && nbr < old.next) begin
              ent.next = nbr;
            end
          end
        end
      end
      default: begin
        ent = old;
      end
    endcase

    if (!dest_ok) begin
      ent = '0;
    end
    res.ent     = ent;
    res.changed = dest_ok && (ent != old);
  end

endmodule
